// ===== rtl/core/hirt_pkg.sv =====
// ----------------------------------------------------------------------------
// hirt_pkg
// Shared types and constants of the HID idle rate timer bank: field layouts
// of the stream items, action and operation codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hirt_pkg;

  localparam int MAX_REPORTS = 8;
  localparam int RPT_W       = $clog2(MAX_REPORTS);
  localparam int NUM_W       = RPT_W + 1;
  localparam int CNT_W       = 16;
  localparam int UNITS_W     = 8;

  localparam logic [CNT_W-1:0]   CNT_MAX           = {CNT_W{1'b1}};
  localparam logic [UNITS_W-1:0] DEFAULT_UNITS_RST = 8'd125;
  localparam logic [3:0]         REPORTS_RST       = 4'd8;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_SET_IDLE  = 3'd1,
    ACT_GET_IDLE  = 3'd2,
    ACT_SEND      = 3'd3,
    ACT_XFER_DONE = 3'd4,
    ACT_INIT      = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_SET_ALL,
    OP_SET_ONE,
    OP_GET,
    OP_SEND,
    OP_XFER,
    OP_INIT
  } op_e;

  typedef enum logic [1:0] {
    REG_IDS_USED = 2'd0,
    REG_REPORTS  = 2'd1,
    REG_DEFAULT  = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               ids_used;
    logic [3:0]         reports;
    logic [UNITS_W-1:0] default_units;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic ptr_inc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk;
    logic last;
  } stat_t;

  // Packed from the top bit down, so the first field lands in the highest bits.
  typedef struct packed {
    logic               pad;
    logic               bus_configured;
    logic [2:0]         report_index;
    logic [15:0]        request_length;
    logic [UNITS_W-1:0] new_units;
    logic [7:0]         req_id;
    logic [2:0]         action;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pad;
    logic       endpoint_free;
    logic [7:0] sent_flags;
    logic [7:0] overflow_flags;
    logic [7:0] idle_value;
    logic       accepted;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/hirt_cfg.sv =====
// ----------------------------------------------------------------------------
// hirt_cfg
// APB register file holding the report addressing mode, the report count and
// the default idle duration.
// ----------------------------------------------------------------------------
`default_nettype none

module hirt_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output hirt_pkg::cfg_t     cfg_o
);
  import hirt_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_e'(paddr[3:2]))
        REG_IDS_USED: cfg_d.ids_used      = pwdata[0];
        REG_REPORTS:  cfg_d.reports       = pwdata[3:0];
        REG_DEFAULT:  cfg_d.default_units = pwdata[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ids_used      <= 1'b1;
      cfg_q.reports       <= REPORTS_RST;
      cfg_q.default_units <= DEFAULT_UNITS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_IDS_USED: prdata = {31'd0, cfg_q.ids_used};
      REG_REPORTS:  prdata = {28'd0, cfg_q.reports};
      REG_DEFAULT:  prdata = {{(32-UNITS_W){1'b0}}, cfg_q.default_units};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/hirt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hirt_ctrl
// Controller: takes one transaction, steps the datapath once or walks it over
// the report range, loads the result register and holds it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hirt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  hirt_pkg::stat_t    stat_i,
  output hirt_pkg::cmd_t     cmd_o
);
  import hirt_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: if (!stat_i.walk || stat_i.last) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.step    = 1'b1;
        cmd_o.ptr_inc = stat_i.walk && !stat_i.last;
      end
      ST_LOAD: cmd_o.load_out = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // The result register is only loaded once the work of the item is over.
  a_load_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> $past(state_q == ST_EXEC))
    else $error("result loaded without an execute step");

  // A new item is taken only while no result is pending.
  a_no_capture_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !out_valid_o)
    else $error("item captured while a result is pending");

  // Execution always follows a capture or a further walk step.
  a_exec_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $past(cmd_o.capture || cmd_o.ptr_inc))
    else $error("execute state entered without a capture");

endmodule

`default_nettype wire

// ===== rtl/core/hirt_dp.sv =====
// ----------------------------------------------------------------------------
// hirt_dp
// Datapath: decodes the captured transaction into an operation and a report
// pointer, holds the per-report timers and flags, and updates one report per
// execute step at the pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module hirt_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  hirt_pkg::cfg_t       cfg_i,
  input  hirt_pkg::in_item_t   item_i,
  input  hirt_pkg::cmd_t       cmd_i,
  output hirt_pkg::stat_t      stat_o,
  output hirt_pkg::out_item_t  out_o
);
  import hirt_pkg::*;

  logic [CNT_W-1:0]   cnt_q   [MAX_REPORTS];
  logic [UNITS_W-1:0] units_q [MAX_REPORTS];
  logic [MAX_REPORTS-1:0] ovf_q;
  logic [MAX_REPORTS-1:0] sent_q;
  logic               ep_free_q;
  logic [RPT_W-1:0]   last_sent_q;

  op_e                op_q, op_d;
  logic [RPT_W-1:0]   ptr_q, ptr_d;
  logic [RPT_W-1:0]   end_q, end_d;
  logic [UNITS_W-1:0] dur_q;
  logic               acc_q;
  logic [UNITS_W-1:0] val_q;
  out_item_t          out_q;

  logic [NUM_W-1:0]   num_rpt;
  logic [RPT_W-1:0]   last_rpt;
  logic               tgt_ok;
  logic [RPT_W-1:0]   tgt;

  logic [CNT_W-1:0]   cnt_cur, cnt_inc;
  logic [UNITS_W-1:0] units_cur;
  logic [CNT_W-1:0]   limit;
  logic [MAX_REPORTS-1:0] units_nz;

  // Number of active reports and the idle request target.
  always_comb begin
    if (!cfg_i.ids_used) begin
      num_rpt = NUM_W'(1);
    end else if (cfg_i.reports == 4'd0) begin
      num_rpt = NUM_W'(1);
    end else if (cfg_i.reports > 4'(MAX_REPORTS)) begin
      num_rpt = NUM_W'(MAX_REPORTS);
    end else begin
      num_rpt = NUM_W'(cfg_i.reports);
    end
    last_rpt = RPT_W'(num_rpt - NUM_W'(1));

    if (cfg_i.ids_used) begin
      tgt_ok = (item_i.req_id != 8'd0) &&
               (item_i.req_id <= 8'(num_rpt));
      tgt    = RPT_W'(item_i.req_id - 8'd1);
    end else begin
      tgt_ok = (item_i.req_id == 8'd0);
      tgt    = '0;
    end
  end

  always_comb begin
    op_d  = OP_NONE;
    ptr_d = '0;
    end_d = '0;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (item_i.bus_configured) op_d = OP_TICK;
        end_d = last_rpt;
      end
      ACT_SET_IDLE: begin
        if (cfg_i.ids_used && item_i.req_id == 8'd0) begin
          op_d  = OP_SET_ALL;
          end_d = last_rpt;
        end else if (tgt_ok) begin
          op_d  = OP_SET_ONE;
          ptr_d = tgt;
        end
      end
      ACT_GET_IDLE: begin
        if (tgt_ok && item_i.request_length == 16'd1) op_d = OP_GET;
        ptr_d = tgt;
      end
      ACT_SEND: begin
        if ((NUM_W'(item_i.report_index) < num_rpt) && ep_free_q) op_d = OP_SEND;
        ptr_d = RPT_W'(item_i.report_index);
      end
      ACT_XFER_DONE: begin
        op_d  = OP_XFER;
        ptr_d = last_sent_q;
      end
      ACT_INIT: begin
        op_d  = OP_INIT;
        end_d = RPT_W'(MAX_REPORTS - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_NONE;
      ptr_q <= '0;
      end_q <= '0;
      acc_q <= 1'b0;
      val_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        op_q  <= op_d;
        ptr_q <= ptr_d;
        end_q <= end_d;
        acc_q <= (op_d != OP_NONE);
        val_q <= '0;
      end else begin
        if (cmd_i.ptr_inc) ptr_q <= ptr_q + RPT_W'(1);
        if (cmd_i.step && op_q == OP_GET) val_q <= units_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) dur_q <= item_i.new_units;
  end

  assign stat_o.walk = (op_q == OP_TICK) || (op_q == OP_SET_ALL) || (op_q == OP_INIT);
  assign stat_o.last = (ptr_q == end_q);

  // Timer arithmetic for the report under the pointer.
  assign cnt_cur   = cnt_q[ptr_q];
  assign units_cur = units_q[ptr_q];
  assign cnt_inc   = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
  assign limit     = {{(CNT_W-UNITS_W-2){1'b0}}, units_cur, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_REPORTS; r++) begin
        cnt_q[r]   <= '0;
        units_q[r] <= DEFAULT_UNITS_RST;
      end
      ovf_q       <= '0;
      sent_q      <= '1;
      ep_free_q   <= 1'b1;
      last_sent_q <= '0;
    end else if (cmd_i.step) begin
      case (op_q)
        OP_TICK: begin
          if (units_cur != '0) begin
            cnt_q[ptr_q] <= cnt_inc;
            if (cnt_inc >= limit) ovf_q[ptr_q] <= 1'b1;
          end
        end
        OP_SET_ALL, OP_SET_ONE: begin
          cnt_q[ptr_q]   <= '0;
          ovf_q[ptr_q]   <= 1'b0;
          units_q[ptr_q] <= dur_q;
        end
        OP_SEND: begin
          cnt_q[ptr_q]  <= '0;
          sent_q[ptr_q] <= 1'b0;
          last_sent_q   <= ptr_q;
          ep_free_q     <= 1'b0;
        end
        OP_XFER: begin
          sent_q[ptr_q] <= 1'b1;
          ep_free_q     <= 1'b1;
        end
        OP_INIT: begin
          cnt_q[ptr_q]   <= '0;
          units_q[ptr_q] <= cfg_i.default_units;
          ovf_q[ptr_q]   <= 1'b0;
          sent_q[ptr_q]  <= 1'b1;
          ep_free_q      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pad            <= '0;
      out_q.endpoint_free  <= ep_free_q;
      out_q.sent_flags     <= sent_q;
      out_q.overflow_flags <= ovf_q;
      out_q.idle_value     <= val_q;
      out_q.accepted       <= acc_q;
    end
  end

  assign out_o = out_q;

  always_comb begin
    for (int r = 0; r < MAX_REPORTS; r++) begin
      units_nz[r] = (units_q[r] != '0);
    end
  end

  // A report with an infinite duration never shows an elapsed period.
  a_ovf_needs_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q & ~units_nz) == '0)
    else $error("overflow flag set on a report with infinite duration");

  // The endpoint turns busy only through an accepted send.
  a_busy_by_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ep_free_q) |-> $past(cmd_i.step && op_q == OP_SEND))
    else $error("endpoint busy without a send");

  // The walk pointer stays inside the range set at capture.
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.walk |-> (ptr_q <= end_q))
    else $error("walk pointer beyond its end");

  // Only get idle returns a duration.
  a_val_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_q != '0) |-> (op_q == OP_GET))
    else $error("idle value set by an operation other than get idle");

endmodule

`default_nettype wire

// ===== rtl/core/hid_idle_rate_timer_bank.sv =====
// ----------------------------------------------------------------------------
// hid_idle_rate_timer_bank
// Flow: a tick with the bus configured or a set-all walks the active reports,
//   init walks all 8, every other action takes one execute step; then the
//   result register is loaded and offered on the result stream.
// Throughput: one item at a time; a walk visits one report per cycle, and a
//   new item is taken only once the result of the last one has been taken.
// Reset: asynchronous active low; timers clear, durations load 125, all sent
//   flags set, endpoint free, configuration back to ID mode with 8 reports.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_idle_rate_timer_bank (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: action[2:0], request ID[7:0], new duration[7:0],
  // request_length[15:0], report_index[2:0], bus_configured, zero pad
  input  wire logic [39:0] s_axis_tdata,
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: accepted, idle_value[7:0], overflow_flags[7:0],
  // sent_flags[7:0], endpoint_free, zero pad
  output logic      [31:0] m_axis_tdata
);
  import hirt_pkg::*;

  cfg_t      cfg;
  cmd_t      cmd;
  stat_t     stat;
  in_item_t  item;
  out_item_t res;

  assign item         = in_item_t'(s_axis_tdata);
  assign m_axis_tdata = 32'(res);

  hirt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hirt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hirt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (res)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HID idle rate timer bank. A predictor of the
// timer, duration and flag state runs beside the block and forms the status
// word each event should produce; the result stream is compared with it word
// by word. Configuration goes through the APB port between phases while the
// block is idle, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hirt_pkg::*;

  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam int CHUNK_EVENTS = 155;
  localparam int LONG_HOLD = 300;

  typedef struct {
    in_item_t ev;
    bit       quiet;
  } pending_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  hid_idle_rate_timer_bank dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state.
  logic               cfg_ids_used;
  logic [3:0]         cfg_reports;
  logic [UNITS_W-1:0] cfg_default;
  logic [CNT_W-1:0]   timer_cnt [MAX_REPORTS];
  logic [UNITS_W-1:0] idle_units [MAX_REPORTS];
  logic [7:0]         ovf_bits;
  logic [7:0]         sent_bits;
  logic               ep_free;
  logic [2:0]         last_sent;

  pending_t  event_q [$];
  out_item_t report_status_q [$];

  int  n_mismatch = 0;
  int  n_events = 0;
  int  n_results = 0;
  logic [7:0] ovf_seen = '0;

  logic in_taken = 1'b0;
  int   gap_left = 0;
  bit   quiet_now = 1'b0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   stall_left = 0;

  // Settings of the fixed phases; one more phase draws its settings at random.
  bit ph_ids [5] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
  int ph_rep [5] = '{3, 1, 8, 5, 8};
  int ph_def [5] = '{0, 255, 1, 2, 125};

  function automatic int report_count();
    if (!cfg_ids_used) return 1;
    if (cfg_reports < 1) return 1;
    if (cfg_reports > MAX_REPORTS) return MAX_REPORTS;
    return int'(cfg_reports);
  endfunction

  function automatic void load_timers();
    for (int r = 0; r < MAX_REPORTS; r++) begin
      timer_cnt[r] = '0;
      idle_units[r] = cfg_default;
    end
    ovf_bits = '0;
    sent_bits = '1;
    ep_free = 1'b1;
  endfunction

  // Maps the ID of an idle request to a report slot; 0 if the ID is invalid.
  function automatic bit idle_slot(logic [7:0] id, int n, output int slot);
    slot = 0;
    if (!cfg_ids_used) return id == 8'd0;
    if (id == 8'd0 || int'(id) > n) return 1'b0;
    slot = int'(id) - 1;
    return 1'b1;
  endfunction

  function automatic void clear_slot(int r, logic [UNITS_W-1:0] units);
    timer_cnt[r] = '0;
    ovf_bits[r] = 1'b0;
    idle_units[r] = units;
  endfunction

  function automatic out_item_t apply_hid_event(in_item_t ev);
    out_item_t st;
    int n;
    int slot;
    n = report_count();
    st = '0;
    case (ev.action)
      ACT_TICK: begin
        if (ev.bus_configured) begin
          for (int r = 0; r < n; r++) begin
            if (idle_units[r] != 0) begin
              if (timer_cnt[r] != CNT_MAX) timer_cnt[r] = timer_cnt[r] + 1'b1;
              if (int'(timer_cnt[r]) >= 4 * int'(idle_units[r])) ovf_bits[r] = 1'b1;
            end
          end
        end
        st.accepted = ev.bus_configured;
      end
      ACT_SET_IDLE: begin
        if (cfg_ids_used && ev.req_id == 8'd0) begin
          for (int r = 0; r < n; r++) clear_slot(r, ev.new_units);
          st.accepted = 1'b1;
        end else if (idle_slot(ev.req_id, n, slot)) begin
          clear_slot(slot, ev.new_units);
          st.accepted = 1'b1;
        end
      end
      ACT_GET_IDLE: begin
        if (idle_slot(ev.req_id, n, slot) && ev.request_length == 16'd1) begin
          st.idle_value = idle_units[slot];
          st.accepted = 1'b1;
        end
      end
      ACT_SEND: begin
        if (int'(ev.report_index) < n && ep_free) begin
          timer_cnt[ev.report_index] = '0;
          sent_bits[ev.report_index] = 1'b0;
          last_sent = ev.report_index;
          ep_free = 1'b0;
          st.accepted = 1'b1;
        end
      end
      ACT_XFER_DONE: begin
        ep_free = 1'b1;
        sent_bits[last_sent] = 1'b1;
        st.accepted = 1'b1;
      end
      ACT_INIT: begin
        load_timers();
        st.accepted = 1'b1;
      end
      default: ;
    endcase
    st.overflow_flags = ovf_bits;
    st.sent_flags = sent_bits;
    st.endpoint_free = ep_free;
    return st;
  endfunction

  function automatic in_item_t mk_event(logic [2:0] act, logic [7:0] id, logic [7:0] dur,
                                        logic [15:0] len, logic [2:0] idx, logic bus);
    in_item_t ev;
    ev = '0;
    ev.action = act;
    ev.req_id = id;
    ev.new_units = dur;
    ev.request_length = len;
    ev.report_index = idx;
    ev.bus_configured = bus;
    return ev;
  endfunction

  function automatic logic [7:0] pick_id(int n);
    if ($urandom_range(0, 99) < 15) return 8'($urandom);
    if (!cfg_ids_used) return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 9)) : 8'd0;
    return 8'($urandom_range(0, n + 1));
  endfunction

  // Mostly well-formed requests with random content, some noise on top.
  function automatic in_item_t random_event();
    in_item_t ev;
    int pick;
    int n;
    n = report_count();
    ev = '0;
    ev.action = 3'($urandom);
    ev.req_id = 8'($urandom);
    ev.new_units = 8'($urandom);
    ev.request_length = 16'($urandom);
    ev.report_index = 3'($urandom);
    ev.bus_configured = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 44) begin
      ev.action = ACT_TICK;
      ev.bus_configured = ($urandom_range(0, 9) != 0);
    end else if (pick < 56) begin
      ev.action = ACT_SET_IDLE;
      ev.req_id = pick_id(n);
      if ($urandom_range(0, 9) < 7) ev.new_units = 8'($urandom_range(0, 3));
    end else if (pick < 68) begin
      ev.action = ACT_GET_IDLE;
      ev.req_id = pick_id(n);
      case ($urandom_range(0, 9))
        0: ev.request_length = 16'd0;
        1, 2: ;
        default: ev.request_length = 16'd1;
      endcase
    end else if (pick < 79) begin
      ev.action = ACT_SEND;
    end else if (pick < 90) begin
      ev.action = ACT_XFER_DONE;
    end else if (pick < 94) begin
      ev.action = ACT_INIT;
    end else if (pick < 97) begin
      ev.action = $urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7;
    end
    return ev;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic push_event(in_item_t ev, bit quiet);
    pending_t p;
    p.ev = ev;
    p.quiet = quiet;
    event_q.push_back(p);
  endtask

  task automatic load_directed();
    push_event(mk_event(ACT_GET_IDLE, 8'd1, 8'd0, 16'd1, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_GET_IDLE, 8'd0, 8'd0, 16'd1, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_GET_IDLE, 8'd8, 8'd0, 16'd1, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_GET_IDLE, 8'd9, 8'd0, 16'd1, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_GET_IDLE, 8'hFF, 8'd0, 16'd1, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_GET_IDLE, 8'd1, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_GET_IDLE, 8'd1, 8'd0, 16'hFFFF, 3'd0, 1'b1), 1'b0);
    // Shortest nonzero duration everywhere, then tick it to overflow.
    push_event(mk_event(ACT_SET_IDLE, 8'd0, 8'd1, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_TICK, 8'd0, 8'd0, 16'd0, 3'd0, 1'b0), 1'b0);
    for (int i = 0; i < 4; i++)
      push_event(mk_event(ACT_TICK, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_SET_IDLE, 8'd9, 8'd5, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_SET_IDLE, 8'd8, 8'hFF, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_SET_IDLE, 8'd3, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_SEND, 8'd0, 8'd0, 16'd0, 3'd7, 1'b1), 1'b0);
    push_event(mk_event(ACT_SEND, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_XFER_DONE, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_XFER_DONE, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_SEND, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_RSVD6, 8'hFF, 8'hFF, 16'hFFFF, 3'd7, 1'b1), 1'b0);
    push_event(mk_event(ACT_RSVD7, 8'hFF, 8'hFF, 16'hFFFF, 3'd7, 1'b1), 1'b0);
    push_event(mk_event(ACT_INIT, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
    push_event(mk_event(ACT_TICK, 8'hFF, 8'hFF, 16'hFFFF, 3'd7, 1'b1), 1'b0);
  endtask

  // Unused actions do not count toward the chunk size.
  task automatic load_random(int count);
    in_item_t ev;
    int done;
    done = 0;
    while (done < count) begin
      ev = random_event();
      push_event(ev, done >= 40 && done < 80);
      if (ev.action <= ACT_INIT) done++;
    end
  endtask

  // Checked at the rising edge, where the queues and the offer are settled.
  task automatic wait_drained();
    while (event_q.size() != 0 || report_status_q.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      n_mismatch++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Sender: a new transaction is offered only once the last one was taken.
  always @(negedge clk_i) begin : sender
    pending_t p;
    if (!s_axis_tvalid || in_taken) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (event_q.size() != 0) begin
        p = event_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p.ev;
        quiet_now <= p.quiet;
        gap_left <= p.quiet ? 0 : draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on each request.
  always @(negedge clk_i) begin : receiver
    int r;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      m_axis_tready <= 1'b0;
      stall_left <= LONG_HOLD;
    end else if (quiet_now) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready <= 1'b1;
      end else if (r < 96) begin
        m_axis_tready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_IDS_USED: cfg_ids_used = pwdata[0];
          REG_REPORTS:  cfg_reports = pwdata[3:0];
          REG_DEFAULT:  cfg_default = pwdata[UNITS_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        report_status_q.push_back(apply_hid_event(in_item_t'(s_axis_tdata)));
        n_events++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'(m_axis_tdata);
        n_results++;
        if (report_status_q.size() == 0) begin
          n_mismatch++;
          $display("%0t ns: result with nothing pending, expected none, actual %0h",
                   $time, m_axis_tdata);
        end else begin
          want = report_status_q.pop_front();
          ovf_seen = ovf_seen | want.overflow_flags;
          check_field("accepted", 8'(want.accepted), 8'(got.accepted));
          check_field("idle_value", want.idle_value, got.idle_value);
          check_field("overflow_flags", want.overflow_flags, got.overflow_flags);
          check_field("sent_flags", want.sent_flags, got.sent_flags);
          check_field("endpoint_free", 8'(want.endpoint_free), 8'(got.endpoint_free));
        end
      end
    end
    in_taken <= s_axis_tvalid && s_axis_tready;
  end

  initial begin : limit
    #5_000_000;
    $display("Timeout: stream did not drain");
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    bit ids;
    int rep;
    int dflt;
    cfg_ids_used = 1'b1;
    cfg_reports = REPORTS_RST;
    cfg_default = DEFAULT_UNITS_RST;
    last_sent = '0;
    load_timers();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    load_directed();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p < 5) begin
        ids = ph_ids[p];
        rep = ph_rep[p];
        dflt = ph_def[p];
      end else begin
        ids = 1'($urandom_range(0, 1));
        rep = $urandom_range(1, 8);
        dflt = $urandom_range(0, 255);
      end
      apb_write(REG_IDS_USED, 32'(ids));
      apb_write(REG_REPORTS, 32'(rep));
      apb_write(REG_DEFAULT, 32'(dflt));
      repeat (2) @(negedge clk_i);
      // Reload the new default duration before the random traffic.
      push_event(mk_event(ACT_INIT, 8'd0, 8'd0, 16'd0, 3'd0, 1'b1), 1'b0);
      load_random(CHUNK_EVENTS);
      // Block the result side while the sender keeps offering.
      hold_seq++;
      // Sender pauses until every result of the first half is back.
      wait_drained();
      load_random(CHUNK_EVENTS);
      wait_drained();
    end

    repeat (30) @(negedge clk_i);
    $display("Ran %0d events over 7 configurations, %0d results checked.", n_events, n_results);
    $display("Overflow flags seen set: %08b; mismatches: %0d.", ovf_seen, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
